// ===== rtl/csa_pkg.sv =====
// ============================================================================
// csa_pkg
// Shared constants, result codes and controller/datapath interface types for
// the contiguous sector allocator.
// ============================================================================
package csa_pkg;

    // Map geometry and limits.
    localparam int SECTOR_COUNT = 1024;
    localparam int SECTOR_BYTES = 512;
    localparam int ALLOC_LIMIT  = 256;

    // The occupancy map is held as words of WORD_BITS sectors.
    localparam int WORD_BITS = 16;
    localparam int WORDS     = SECTOR_COUNT / WORD_BITS;
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int BIDX_W    = $clog2(WORD_BITS);

    // Field widths.
    localparam int BYTES_W  = 20;
    localparam int SECT_W   = 10;
    localparam int CNT_W    = 11;
    localparam int SB_SHIFT = $clog2(SECTOR_BYTES);
    localparam int NEED_W   = BYTES_W + 1 - SB_SHIFT;
    localparam int RUN_W    = CNT_W;
    localparam int LIVE_W   = $clog2(ALLOC_LIMIT + 1);

    // Stream payload widths.
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    scan_init;
        logic    scan;
        logic    free_init;
        logic    mark;
        logic    set_outcome;
        status_t outcome;
        logic    out_load;
    } csa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic limit_hit;
        logic need_bad;
        logic range_bad;
        logic free_empty;
        logic hit;
        logic scan_miss;
        logic mark_done;
    } csa_stat_t;

endpackage

// ===== rtl/csa_ram.sv =====
// ============================================================================
// csa_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module csa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csa_datapath.sv =====
// ============================================================================
// csa_datapath
// Occupancy map storage, first-fit word scanner, range marker, live
// allocation counter and result register.
// ============================================================================
module csa_datapath import csa_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  csa_cmd_t           cmd,
    output csa_stat_t          stat,
    input  logic               kind,
    input  logic [BYTES_W-1:0] request_bytes,
    input  logic [SECT_W-1:0]  free_start,
    input  logic [CNT_W-1:0]   free_count,
    output logic               ok,
    output logic [1:0]         status,
    output logic [SECT_W-1:0]  run_start,
    output logic [CNT_W-1:0]   run_length
);

    // Latched request.
    logic               kind_reg;
    logic [NEED_W-1:0]  need_reg,   need_next;
    logic [SECT_W-1:0]  fstart_reg;
    logic [CNT_W-1:0]   fcount_reg;

    // Clearing pass, scan and mark control.
    logic [WIDX_W-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [WIDX_W:0]    rd_ptr_reg,  rd_ptr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [WIDX_W-1:0]  rd_word_reg, rd_word_next;
    logic [RUN_W-1:0]   run_reg,     run_next;
    logic [SECT_W-1:0]  lo_reg,      lo_next;
    logic [SECT_W-1:0]  hi_reg,      hi_next;
    logic               set_reg,     set_next;
    logic [WIDX_W-1:0]  mk_ptr_reg,  mk_ptr_next;
    logic               mk_more_reg, mk_more_next;
    logic               mk_pend_reg, mk_pend_next;
    logic [WIDX_W-1:0]  mk_word_reg, mk_word_next;
    logic [LIVE_W-1:0]  live_reg,    live_next;
    status_t            outcome_reg, outcome_next;

    // Result register.
    logic               ok_reg,      ok_next;
    logic [1:0]         status_reg,  status_next;
    logic [SECT_W-1:0]  start_reg,   start_next;
    logic [CNT_W-1:0]   len_reg,     len_next;

    // Map RAM.
    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WIDX_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Scan and mark helpers.
    logic [WORD_BITS-1:0] hit_vec;
    logic [RUN_W-1:0]     carry_run;
    logic [BIDX_W-1:0]    hit_idx;
    logic [SECT_W-1:0]    hit_end;
    logic [NEED_W-1:0]    hit_start_w;
    logic [NEED_W-1:0]    free_sum;
    logic [NEED_W-1:0]    free_last_w;
    logic [BIDX_W-1:0]    mask_lo;
    logic [BIDX_W-1:0]    mask_hi;
    logic [WORD_BITS-1:0] mark_mask;
    logic [BYTES_W:0]     bytes_round;
    logic                 mk_issue;

    csa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // For every bit of the returned word, the length of the free run that
    // ends there, counting the run carried in from earlier words. Each lane
    // is independent; the lowest lane that reaches the need is the hit.
    always_comb
    begin
        logic             has_one;
        int               last_one;
        logic [RUN_W-1:0] len;
        hit_vec   = '0;
        carry_run = '0;
        hit_idx   = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            has_one  = 1'b0;
            last_one = 0;
            for (int k = 0; k < WORD_BITS; k++)
            begin
                if (k <= j && ram_rdata[k])
                begin
                    has_one  = 1'b1;
                    last_one = k;
                end
            end
            if (has_one)
            begin
                len = RUN_W'(j) - RUN_W'(last_one);
            end
            else
            begin
                len = run_reg + RUN_W'(j + 1);
            end
            hit_vec[j] = !ram_rdata[j] && (NEED_W'(len) >= need_reg);
            if (j == WORD_BITS - 1)
            begin
                carry_run = len;
            end
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_idx = BIDX_W'(j);
            end
        end
    end

    assign hit_end     = {rd_word_reg, hit_idx};
    assign hit_start_w = NEED_W'(hit_end) + NEED_W'(1) - need_reg;
    assign free_sum    = NEED_W'(fstart_reg) + NEED_W'(fcount_reg);
    assign free_last_w = free_sum - NEED_W'(1);
    assign bytes_round = {1'b0, request_bytes} + (BYTES_W + 1)'(SECTOR_BYTES - 1);
    assign need_next   = bytes_round[BYTES_W:SB_SHIFT];

    // Bits of the word under write that fall inside [lo, hi].
    assign mask_lo   = (mk_word_reg == lo_reg[SECT_W-1:BIDX_W]) ? lo_reg[BIDX_W-1:0] : '0;
    assign mask_hi   = (mk_word_reg == hi_reg[SECT_W-1:BIDX_W]) ? hi_reg[BIDX_W-1:0] : '1;
    assign mark_mask = ({WORD_BITS{1'b1}} << mask_lo)
                     & ({WORD_BITS{1'b1}} >> (BIDX_W'(WORD_BITS - 1) - mask_hi));

    assign mk_issue  = cmd.mark && mk_more_reg;
    assign ram_raddr = cmd.mark ? mk_ptr_reg : rd_ptr_reg[WIDX_W-1:0];
    assign ram_we    = cmd.clr || mk_pend_reg;
    assign ram_waddr = cmd.clr ? clr_ptr_reg : mk_word_reg;
    assign ram_wdata = cmd.clr ? '0
                     : (set_reg ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask));

    always_comb
    begin
        stat.clr_last   = (clr_ptr_reg == WIDX_W'(WORDS - 1));
        stat.is_free    = kind_reg;
        stat.limit_hit  = (live_reg >= LIVE_W'(ALLOC_LIMIT));
        stat.need_bad   = (need_reg == '0) || (need_reg > NEED_W'(SECTOR_COUNT));
        stat.range_bad  = (free_sum > NEED_W'(SECTOR_COUNT));
        stat.free_empty = (fcount_reg == '0);
        stat.hit        = rd_pend_reg && (|hit_vec);
        stat.scan_miss  = rd_pend_reg && !(|hit_vec) && (rd_word_reg == WIDX_W'(WORDS - 1));
        stat.mark_done  = mk_pend_reg && (mk_word_reg == hi_reg[SECT_W-1:BIDX_W]);
    end

    always_comb
    begin
        clr_ptr_next = clr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_pend_next = 1'b0;
        rd_word_next = rd_word_reg;
        run_next     = run_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        set_next     = set_reg;
        mk_ptr_next  = mk_ptr_reg;
        mk_more_next = mk_more_reg;
        mk_pend_next = mk_issue;
        mk_word_next = mk_word_reg;
        live_next    = live_reg;
        outcome_next = outcome_reg;
        ok_next      = ok_reg;
        status_next  = status_reg;
        start_next   = start_reg;
        len_next     = len_reg;

        if (cmd.clr)
        begin
            clr_ptr_next = clr_ptr_reg + WIDX_W'(1);
        end

        if (cmd.scan_init)
        begin
            rd_ptr_next = '0;
            run_next    = '0;
        end

        if (cmd.scan)
        begin
            if (rd_ptr_reg < (WIDX_W + 1)'(WORDS))
            begin
                rd_pend_next = 1'b1;
                rd_word_next = rd_ptr_reg[WIDX_W-1:0];
                rd_ptr_next  = rd_ptr_reg + (WIDX_W + 1)'(1);
            end
            if (rd_pend_reg)
            begin
                run_next = carry_run;
                if (|hit_vec)
                begin
                    lo_next      = hit_start_w[SECT_W-1:0];
                    hi_next      = hit_end;
                    set_next     = 1'b1;
                    mk_ptr_next  = hit_start_w[SECT_W-1:BIDX_W];
                    mk_more_next = 1'b1;
                end
            end
        end

        if (cmd.free_init)
        begin
            lo_next      = fstart_reg;
            hi_next      = free_last_w[SECT_W-1:0];
            set_next     = 1'b0;
            mk_ptr_next  = fstart_reg[SECT_W-1:BIDX_W];
            mk_more_next = 1'b1;
        end

        if (mk_issue)
        begin
            mk_word_next = mk_ptr_reg;
            if (mk_ptr_reg == hi_reg[SECT_W-1:BIDX_W])
            begin
                mk_more_next = 1'b0;
            end
            else
            begin
                mk_ptr_next = mk_ptr_reg + WIDX_W'(1);
            end
        end

        if (cmd.set_outcome)
        begin
            outcome_next = cmd.outcome;
        end

        if (cmd.out_load)
        begin
            ok_next     = (outcome_reg == ST_OK);
            status_next = outcome_reg;
            start_next  = '0;
            len_next    = '0;
            if (outcome_reg == ST_OK)
            begin
                if (kind_reg)
                begin
                    len_next = fcount_reg;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - LIVE_W'(1);
                    end
                end
                else
                begin
                    start_next = lo_reg;
                    len_next   = need_reg[CNT_W-1:0];
                    live_next  = live_reg + LIVE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            rd_pend_reg <= 1'b0;
            mk_more_reg <= 1'b0;
            mk_pend_reg <= 1'b0;
            live_reg    <= '0;
        end
        else
        begin
            clr_ptr_reg <= clr_ptr_next;
            rd_pend_reg <= rd_pend_next;
            mk_more_reg <= mk_more_next;
            mk_pend_reg <= mk_pend_next;
            live_reg    <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            need_reg   <= need_next;
            fstart_reg <= free_start;
            fcount_reg <= free_count;
        end
        rd_ptr_reg  <= rd_ptr_next;
        rd_word_reg <= rd_word_next;
        run_reg     <= run_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        set_reg     <= set_next;
        mk_ptr_reg  <= mk_ptr_next;
        mk_word_reg <= mk_word_next;
        outcome_reg <= outcome_next;
        ok_reg      <= ok_next;
        status_reg  <= status_next;
        start_reg   <= start_next;
        len_reg     <= len_next;
    end

    assign ok         = ok_reg;
    assign status     = status_reg;
    assign run_start  = start_reg;
    assign run_length = len_reg;

endmodule

// ===== rtl/csa_ctrl.sv =====
// ============================================================================
// csa_ctrl
// Request sequencer: clearing pass, request checks, scan, mark and result
// hand-off to the output register.
// ============================================================================
module csa_ctrl import csa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  csa_stat_t stat,
    output csa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_MARK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.outcome    = ST_OK;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.limit_hit)
                    begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = ST_LIMIT;
                        state_next      = S_DONE;
                    end
                    else if (stat.need_bad)
                    begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = ST_NOSPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else
                begin
                    if (stat.range_bad)
                    begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else if (stat.free_empty)
                    begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cmd.free_init = 1'b1;
                        state_next    = S_MARK;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_MARK;
                end
                else if (stat.scan_miss)
                begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = ST_NOSPACE;
                    state_next      = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (stat.mark_done)
                begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/contiguous_sector_allocator.sv =====
// ============================================================================
// contiguous_sector_allocator
// First-fit contiguous sector allocator over a one-bit-per-sector occupancy
// map, with a saturating count of live allocations.
// ============================================================================
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: kind; tdata: request
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: ok, status; tdata: run
//
// After reset the block clears the map, one 16-sector word per cycle, and
// holds s_axis_tready low during that pass.
// An allocate scans the map word by word for the first free run long enough,
// then marks that run word by word; one whose scan finds no room reads every
// map word. Scan and mark share the single map RAM read port. A free clears
// only the words it touches. Requests refused by the up-front checks, and
// empty frees, skip the scan and mark.
// One item is in work at a time. A finished result waits in the output
// register while the next item is accepted; if it is still not taken when
// that next item completes, the block stalls before loading the new result.
//
module contiguous_sector_allocator import csa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [19:0] request_bytes, [29:20] free_start, [40:30] free_count, [47:41] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind (0 allocate, 1 free)
    input  logic [IN_USER_W-1:0]  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [9:0] run_start, [20:10] run_length, [23:21] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] ok, [2:1] status
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    csa_cmd_t          cmd;
    csa_stat_t         stat;
    logic              res_ok;
    logic [1:0]        res_status;
    logic [SECT_W-1:0] res_start;
    logic [CNT_W-1:0]  res_length;

    // The controller sequences the request; the datapath owns the map RAM,
    // the scanner and the result register.
    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csa_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (s_axis_tuser[0]),
        .request_bytes (s_axis_tdata[BYTES_W-1:0]),
        .free_start    (s_axis_tdata[BYTES_W+SECT_W-1:BYTES_W]),
        .free_count    (s_axis_tdata[BYTES_W+SECT_W+CNT_W-1:BYTES_W+SECT_W]),
        .ok            (res_ok),
        .status        (res_status),
        .run_start     (res_start),
        .run_length    (res_length)
    );

    assign m_axis_tdata = {(OUT_DATA_W - SECT_W - CNT_W)'(0), res_length, res_start};
    assign m_axis_tuser = {res_status, res_ok};

`ifndef SYNTHESIS
    // At most one of clear, load, scan, mark and result load is commanded in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr, cmd.load, cmd.scan, cmd.mark, cmd.out_load}))
        else $error("csa: conflicting datapath commands");

    // No request is taken while the map is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !s_axis_tready)
        else $error("csa: input accepted during clearing pass");

    // A waiting result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && m_axis_tvalid) |-> m_axis_tready)
        else $error("csa: pending result overwritten");

    // A scan word never reports both a hit and the end of the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.hit && stat.scan_miss))
        else $error("csa: scan hit and miss together");
`endif

endmodule
